### rtl/lhbp_pkg.sv
// shared constants, types and codes for the local-history branch predictor
package lhbp_pkg;

  localparam int unsigned HISTORY_ENTRIES = 12281;
  localparam int unsigned HISTORY_BITS    = 4;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ROW_W  = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
  localparam int unsigned REM_W  = $clog2(2 * HISTORY_ENTRIES);

  // counters of one history row sit side by side in one memory word
  localparam int unsigned CTR_W        = 2;
  localparam int unsigned CTRS_PER_ROW = 1 << HISTORY_BITS;
  localparam int unsigned CTR_ROW_W    = CTR_W * CTRS_PER_ROW;

  // floor(2^32 / entries), the quotient estimate is at most one short
  localparam logic [ADDR_W:0] RECIP = (ADDR_W + 1)'((64'd1 << ADDR_W) / HISTORY_ENTRIES);

  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_RESET = 2'd2;

  localparam logic [HISTORY_BITS-1:0] HIST_RESET = '0;
  localparam logic [CTR_ROW_W-1:0]    CTR_ROW_RESET = {CTRS_PER_ROW{CTR_RESET}};

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(HISTORY_ENTRIES - 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_TRAIN   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic             resolved_taken;
    logic [ROW_W-1:0] row;
  } work_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

endpackage

### rtl/lhbp_if.sv
// handshake channels for predictor requests and responses
interface lhbp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [lhbp_pkg::ADDR_W-1:0] branch_address;
  logic                        resolved_taken;

  modport source (output valid, output command, output branch_address,
                  output resolved_taken, input ready);
  modport sink   (input valid, input command, input branch_address,
                  input resolved_taken, output ready);
endinterface

interface lhbp_rsp_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, output predict_taken, input ready);
  modport sink   (input valid, input predict_taken, output ready);
endinterface

### rtl/lhbp_front.sv
// front end: accepts requests and reduces the address to a history row
module lhbp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lhbp_req_if.sink               req_i,
  input  lhbp_pkg::back_status_t status_i,
  output lhbp_pkg::work_t        work_o,
  output logic                   work_valid_o,
  input  logic                   work_ready_i
);

  logic                        adv;
  logic                        accept;
  logic [63:0]                 prod;
  logic [63:0]                 qd;

  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_cmd_q;
  logic                        s1_taken_q;
  logic [lhbp_pkg::ADDR_W-1:0] s1_addr_q;
  logic [lhbp_pkg::ADDR_W-1:0] s1_quot_q;

  logic                        s2_valid_q, s2_valid_d;
  logic                        s2_cmd_q;
  logic                        s2_taken_q;
  logic [lhbp_pkg::REM_W-1:0]  s2_rem_q, s2_rem_d;
  logic [lhbp_pkg::REM_W-1:0]  rem_fix;

  assign adv         = !s2_valid_q || work_ready_i;
  assign req_i.ready = adv && status_i.init_done;
  assign accept      = req_i.valid && req_i.ready;

  // quotient estimate by reciprocal multiply
  assign prod = 64'(req_i.branch_address) * 64'(lhbp_pkg::RECIP);

  // remainder before correction, known to be below twice the entry count
  assign qd       = 64'(s1_quot_q) * 64'(lhbp_pkg::HISTORY_ENTRIES);
  assign s2_rem_d = s1_addr_q[lhbp_pkg::REM_W-1:0] - qd[lhbp_pkg::REM_W-1:0];

  assign s1_valid_d = accept;
  assign s2_valid_d = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q   <= req_i.command;
      s1_taken_q <= req_i.resolved_taken;
      s1_addr_q  <= req_i.branch_address;
      s1_quot_q  <= prod[63:32];
      s2_cmd_q   <= s1_cmd_q;
      s2_taken_q <= s1_taken_q;
      s2_rem_q   <= s2_rem_d;
    end
  end

  assign rem_fix = (s2_rem_q >= lhbp_pkg::REM_W'(lhbp_pkg::HISTORY_ENTRIES)) ?
                   s2_rem_q - lhbp_pkg::REM_W'(lhbp_pkg::HISTORY_ENTRIES) : s2_rem_q;

  assign work_valid_o          = s2_valid_q;
  assign work_o.command        = lhbp_pkg::cmd_e'(s2_cmd_q);
  assign work_o.resolved_taken = s2_taken_q;
  assign work_o.row            = rem_fix[lhbp_pkg::ROW_W-1:0];

endmodule

### rtl/lhbp_queue.sv
// short fifo between front and back ends
module lhbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lhbp_pkg::work_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output lhbp_pkg::work_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  lhbp_pkg::work_t                 entries_q [lhbp_pkg::QUEUE_DEPTH];
  logic [lhbp_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lhbp_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lhbp_pkg::QPTR_W:0]       count_q, count_d;
  logic                            push;
  logic                            pop;

  assign push_ready_o = (count_q != (lhbp_pkg::QPTR_W + 1)'(lhbp_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + lhbp_pkg::QPTR_W'(push);
  assign rd_ptr_d = rd_ptr_q + lhbp_pkg::QPTR_W'(pop);
  assign count_d  = count_q + (lhbp_pkg::QPTR_W + 1)'(push) - (lhbp_pkg::QPTR_W + 1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/lhbp_back.sv
// back end: history and counter memories, clearing pass, update and response
module lhbp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lhbp_pkg::work_t        work_i,
  input  logic                   work_valid_i,
  output logic                   work_ready_o,
  output lhbp_pkg::back_status_t status_o,
  lhbp_rsp_if.source             rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [lhbp_pkg::HISTORY_BITS-1:0] hist_mem [lhbp_pkg::HISTORY_ENTRIES];
  logic [lhbp_pkg::CTR_ROW_W-1:0]    ctr_mem  [lhbp_pkg::HISTORY_ENTRIES];

  logic                              state_q, state_d;
  logic                              clr_q, clr_d;
  logic [lhbp_pkg::ROW_W-1:0]        clr_idx_q, clr_idx_d;
  lhbp_pkg::work_t                   cur_q;
  logic [lhbp_pkg::HISTORY_BITS-1:0] hist_rd_q;
  logic [lhbp_pkg::CTR_ROW_W-1:0]    row_rd_q;
  logic                              out_valid_q, out_valid_d;
  logic                              out_pred_q;

  logic                              pop;
  logic                              fire;
  logic [lhbp_pkg::CTR_W-1:0]        ctr;
  logic [lhbp_pkg::CTR_W-1:0]        ctr_new;
  logic [lhbp_pkg::HISTORY_BITS-1:0] hist_new;
  logic [lhbp_pkg::CTR_ROW_W-1:0]    row_new;
  logic                              mem_we;
  logic [lhbp_pkg::ROW_W-1:0]        mem_wa;
  logic [lhbp_pkg::HISTORY_BITS-1:0] hist_wd;
  logic [lhbp_pkg::CTR_ROW_W-1:0]    ctr_wd;

  assign work_ready_o       = !clr_q && (state_q == ST_IDLE);
  assign pop                = work_valid_i && work_ready_o;
  assign fire               = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);
  assign status_o.init_done = !clr_q;

  // counter picked by the history within the row
  assign ctr = row_rd_q[{hist_rd_q, 1'b0} +: lhbp_pkg::CTR_W];

  always_comb begin
    if (cur_q.resolved_taken) begin
      ctr_new = (ctr == lhbp_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
    end else begin
      ctr_new = (ctr == lhbp_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
    end
    row_new = row_rd_q;
    row_new[{hist_rd_q, 1'b0} +: lhbp_pkg::CTR_W] = ctr_new;
    hist_new = lhbp_pkg::HISTORY_BITS'({hist_rd_q, cur_q.resolved_taken});
  end

  assign mem_we  = clr_q || (fire && (cur_q.command == lhbp_pkg::CMD_TRAIN));
  assign mem_wa  = clr_q ? clr_idx_q : cur_q.row;
  assign hist_wd = clr_q ? lhbp_pkg::HIST_RESET : hist_new;
  assign ctr_wd  = clr_q ? lhbp_pkg::CTR_ROW_RESET : row_new;

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = pop ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = fire ? ST_IDLE : ST_EXEC;
      default: state_d = ST_IDLE;
    endcase
  end

  assign clr_d       = clr_q && (clr_idx_q != lhbp_pkg::ROW_LAST);
  assign clr_idx_d   = clr_q ? clr_idx_q + lhbp_pkg::ROW_W'(1) : clr_idx_q;
  assign out_valid_d = fire || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= work_i;
    end
    if (fire) begin
      out_pred_q <= ctr[1];
    end
  end

  // memories: registered reads at pop, single write port
  always_ff @(posedge clk_i) begin
    if (pop) begin
      hist_rd_q <= hist_mem[work_i.row];
      row_rd_q  <= ctr_mem[work_i.row];
    end
    if (mem_we) begin
      hist_mem[mem_wa] <= hist_wd;
      ctr_mem[mem_wa]  <= ctr_wd;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.predict_taken = out_pred_q;

`ifndef SYNTHESIS
  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !pop)
    else $error("item taken during clearing pass");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("response raised outside execute step");

  a_train_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clr_q) |-> (state_q == ST_EXEC))
    else $error("memory write outside execute step");

  a_exec_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == ST_EXEC))
    else $error("popped beat not executed");
`endif

endmodule

### rtl/local_history_branch_predictor_core.sv
// top level of the two-level local-history branch predictor
//
// req_i carries one beat per branch: command (0 predict, 1 train), the
// 32-bit branch address and, for training, the resolved direction.
// rsp_o returns exactly one beat per request, in order, holding the
// prediction read before that request's own update.
// The address is reduced to a history row by a reciprocal multiply and
// one correction over two front-end stages; a two-entry queue sits
// between front and back ends.
// The back end reads the history and counter row together when it takes a
// beat, then updates and responds in its execute step, which waits while the
// response register is stalled; it takes no new beat until that step ends.
// After reset both memories are swept one row per cycle over all 12281
// history rows; req_i.ready stays low until the sweep ends.
// A stalled receiver holds the response register; the queue and front
// stages fill behind it and then req_i.ready drops.
module local_history_branch_predictor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhbp_req_if.sink   req_i,
  lhbp_rsp_if.source rsp_o
);

  lhbp_pkg::work_t        front_work;
  logic                   front_valid;
  logic                   front_ready;
  lhbp_pkg::work_t        back_work;
  logic                   back_valid;
  logic                   back_ready;
  lhbp_pkg::back_status_t back_status;

  lhbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .status_i     (back_status),
    .work_o       (front_work),
    .work_valid_o (front_valid),
    .work_ready_i (front_ready)
  );

  lhbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_work),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_work),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  lhbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (back_work),
    .work_valid_i (back_valid),
    .work_ready_o (back_ready),
    .status_o     (back_status),
    .rsp_o        (rsp_o)
  );

endmodule

### dv/lhbp_checker.sv
// scoreboard for the local-history branch predictor: predicts every response beat and compares
`timescale 1ns / 100ps
module lhbp_checker
  import lhbp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lhbp_req_if  req_i,
  lhbp_rsp_if  rsp_i,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  localparam int unsigned SLOT_W          = ROW_W + HISTORY_BITS;
  localparam int unsigned COUNTER_ENTRIES = HISTORY_ENTRIES << HISTORY_BITS;
  localparam logic [CTR_W-1:0] TAKEN_THRESHOLD = 2'd2;
  localparam int MAX_PRINTED = 100;

  logic [HISTORY_BITS-1:0] branch_history [HISTORY_ENTRIES];
  logic [CTR_W-1:0]        pattern_ctr    [COUNTER_ENTRIES];
  bit                      expected_dir_q [$];
  bit                      expected_dir;
  int                      mismatches = 0;
  int unsigned             rsp_beats  = 0;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] lhbp mismatch: %s", $time, what);
    end
  endtask

  // direction read before the update; a train command then also trains the counter and the history
  function automatic bit lookup_and_train(cmd_e command, logic [ADDR_W-1:0] addr,
                                          logic taken);
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic [CTR_W-1:0]  ctr;
    bit                dir;
    row  = ROW_W'(addr % HISTORY_ENTRIES);
    slot = {row, branch_history[row]};
    ctr  = pattern_ctr[slot];
    dir  = (ctr >= TAKEN_THRESHOLD);
    if (command == CMD_TRAIN) begin
      if (taken) begin
        if (ctr != CTR_MAX) ctr = ctr + 1'b1;
      end else begin
        if (ctr != CTR_MIN) ctr = ctr - 1'b1;
      end
      pattern_ctr[slot]   = ctr;
      // oldest outcome falls off the top
      branch_history[row] = HISTORY_BITS'({branch_history[row], taken});
    end
    return dir;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (branch_history[i]) branch_history[i] = HIST_RESET;
      foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_RESET;
      expected_dir_q.delete();
      rsp_beats = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_beats++;
        if (expected_dir_q.size() == 0) begin
          report_mismatch($sformatf("response beat %0d with nothing expected", rsp_beats));
        end else begin
          expected_dir = expected_dir_q.pop_front();
          if (rsp_i.predict_taken !== expected_dir) begin
            report_mismatch($sformatf("beat %0d predict_taken %b, expected %b",
                                      rsp_beats, rsp_i.predict_taken, expected_dir));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_dir_q.push_back(lookup_and_train(cmd_e'(req_i.command),
                                                  req_i.branch_address,
                                                  req_i.resolved_taken));
      end
    end
    outstanding_o    <= expected_dir_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

### dv/local_history_branch_predictor_core_tb.sv
// testbench top for the local-history branch predictor: clock, reset, traffic and verdict
`timescale 1ns / 100ps
module local_history_branch_predictor_core_tb;
  import lhbp_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1330;
  localparam int POOL_SIZE      = 8;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 250_000;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   outstanding;
  bit   calm;
  int   hold_off_req;

  lhbp_req_if req ();
  lhbp_rsp_if rsp ();

  local_history_branch_predictor_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  lhbp_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("** local_history_branch_predictor_core: FAILED **");
    $finish;
  end

  // response side: random stalls, a calm window and one long hold-off on request
  initial begin : rsp_drain
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != hold_seen) begin
        hold_seen = hold_off_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // called at a rising edge, returns at the edge that accepts the beat
  task automatic send_branch(cmd_e command, logic [ADDR_W-1:0] addr, logic taken);
    if (!calm && $urandom_range(99) < 10) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    req.valid          <= 1'b1;
    req.command        <= command;
    req.branch_address <= addr;
    req.resolved_taken <= taken;
    do @(posedge clk_i); while (!req.ready);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] pool_addr    [POOL_SIZE];
    bit   [3:0]        pool_pattern [POOL_SIZE];
    bit   [1:0]        pool_phase   [POOL_SIZE];
    int                k;
    logic              taken;
    cmd_e              command;

    req.valid          = 1'b0;
    req.command        = CMD_PREDICT;
    req.branch_address = '0;
    req.resolved_taken = 1'b0;
    calm               = 1'b0;
    hold_off_req       = 0;
    rst_ni             = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: address extremes, aliasing rows, ignored direction on predict
    send_branch(CMD_PREDICT, '0, 1'b1);
    send_branch(CMD_PREDICT, '1, 1'b0);
    send_branch(CMD_TRAIN, '1, 1'b0);
    send_branch(CMD_TRAIN, ADDR_W'(HISTORY_ENTRIES - 1), 1'b1);
    send_branch(CMD_PREDICT, ADDR_W'(2 * HISTORY_ENTRIES - 1), 1'b0);
    // taken run fills the history with ones and pins the counter at its top
    repeat (7) send_branch(CMD_TRAIN, 32'h8000_0000, 1'b1);
    send_branch(CMD_PREDICT, 32'h8000_0000, 1'b0);
    // not-taken run on row zero through an aliasing address pins it at the bottom
    repeat (4) send_branch(CMD_TRAIN, ADDR_W'(HISTORY_ENTRIES), 1'b0);
    send_branch(CMD_PREDICT, '0, 1'b1);
    send_branch(CMD_TRAIN, '0, 1'b1);

    // random: mostly patterned training on a small address pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) begin
        foreach (pool_addr[j]) begin
          // odd entries share a row with their even neighbour
          pool_addr[j]    = (j % 2 == 1) ? pool_addr[j-1] + HISTORY_ENTRIES : $urandom;
          pool_pattern[j] = 4'($urandom);
          pool_phase[j]   = '0;
        end
      end
      if (n == 150) hold_off_req <= hold_off_req + 1;
      if (n == 500) calm <= 1'b1;
      if (n == 800) calm <= 1'b0;
      if (n == 950) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 80) begin
        k       = $urandom_range(POOL_SIZE - 1);
        taken   = pool_pattern[k][pool_phase[k]];
        command = ($urandom_range(99) < 70) ? CMD_TRAIN : CMD_PREDICT;
        if (command == CMD_TRAIN) pool_phase[k] = pool_phase[k] + 1'b1;
        if ($urandom_range(99) < 10) taken = ~taken;
        send_branch(command, pool_addr[k], taken);
      end else begin
        send_branch(cmd_e'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
      end
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** local_history_branch_predictor_core: PASSED **");
    end else begin
      $display("** local_history_branch_predictor_core: FAILED **");
    end
    $finish;
  end

endmodule
